// ----- design/biquad_cascade_lowpass_filter_core_assert.svh -----
// assertion macros for the biquad cascade core
// no dependencies; included by the top level
`ifndef BIQUAD_CASCADE_LOWPASS_FILTER_CORE_ASSERT_SVH
`define BIQUAD_CASCADE_LOWPASS_FILTER_CORE_ASSERT_SVH

// same-cycle implication
`define BQC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BQC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/bqc_pkg.sv -----
// shared types, constants, microcode table and helpers for the biquad cascade
// no dependencies
package bqc_pkg;

  localparam int SECTIONS_DEF = 2;
  localparam int MAX_SECTIONS = 2;

  localparam int X_W    = 16;
  localparam int G_W    = 32;
  localparam int C_W    = 32;
  localparam int H_W    = 48;
  localparam int HL_W   = 24;
  localparam int FRAC_W = 16;
  localparam int Q_W    = H_W - FRAC_W;
  localparam int MA_W   = HL_W + 1;
  localparam int MB_W   = C_W + 1;
  localparam int M_W    = MA_W + MB_W;
  localparam int P_W    = 82;
  localparam int CSH    = 28;
  localparam int T_W    = P_W - CSH;
  localparam int ACC_W  = 56;
  localparam int CFG_W  = 64;
  localparam int CFG_IDX_W = 3;
  localparam int STEP_W = 4;

  localparam logic [CFG_W-1:0] ZERO_PAIR_RESET = 64'h1000_0000_1000_0000;

  localparam logic signed [ACC_W-1:0] H_MAX_EXT =
    {{(ACC_W-H_W+1){1'b0}}, {(H_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] H_MIN_EXT = ~H_MAX_EXT;

  typedef enum logic [2:0] {
    R_GAIN, R_POLE1, R_ZERO1, R_POLE2, R_ZERO2, R_APPLY_RX, R_APPLY_TX
  } reg_idx_t;

  typedef enum logic [1:0] {M_NONE, M_GAIN, M_HH, M_HL} mul_op_t;
  typedef enum logic {S_H1, S_H2} hist_sel_t;
  typedef enum logic [1:0] {K_B1, K_B2, K_A1, K_A2} coef_sel_t;
  typedef enum logic [1:0] {P_NONE, P_LOAD, P_ADD, P_GAIN} prod_op_t;
  typedef enum logic [2:0] {A_NONE, A_V, A_LOADV, A_SUB, A_ADD, A_W, A_Y} acc_op_t;
  typedef enum logic [1:0] {J_NONE, J_LOOP, J_END} jump_t;

  typedef struct packed {
    mul_op_t   mul;
    hist_sel_t src;
    coef_sel_t coef;
    prod_op_t  prod;
    acc_op_t   acc;
    jump_t     jump;
  } ctl_t;

  typedef struct packed {
    logic run;
    logic done;
  } seq_stat_t;

  localparam ctl_t CTL_NOP = '{M_NONE, S_H1, K_B1, P_NONE, A_NONE, J_NONE};
  localparam logic [STEP_W-1:0] LOOP_STEP = 4'd3;

  function automatic ctl_t mk(input mul_op_t m, input hist_sel_t s, input coef_sel_t k,
                              input prod_op_t p, input acc_op_t a, input jump_t j);
    ctl_t c;
    c.mul  = m;
    c.src  = s;
    c.coef = k;
    c.prod = p;
    c.acc  = a;
    c.jump = j;
    return c;
  endfunction

  // products overlap: hi pass, lo pass + load, add, then accumulate
  function automatic ctl_t ucode(input logic [STEP_W-1:0] step);
    ctl_t c;
    c = CTL_NOP;
    case (step)
      4'd0:  c = mk(M_GAIN, S_H1, K_B1, P_NONE, A_NONE,  J_NONE);
      4'd1:  c = mk(M_NONE, S_H1, K_B1, P_GAIN, A_NONE,  J_NONE);
      4'd2:  c = mk(M_NONE, S_H1, K_B1, P_NONE, A_V,     J_NONE);
      // section loop entry
      4'd3:  c = mk(M_HH,   S_H1, K_B1, P_NONE, A_LOADV, J_NONE);
      4'd4:  c = mk(M_HL,   S_H1, K_B1, P_LOAD, A_NONE,  J_NONE);
      4'd5:  c = mk(M_HH,   S_H2, K_B2, P_ADD,  A_NONE,  J_NONE);
      4'd6:  c = mk(M_HL,   S_H2, K_B2, P_LOAD, A_SUB,   J_NONE);
      4'd7:  c = mk(M_HH,   S_H1, K_A1, P_ADD,  A_NONE,  J_NONE);
      4'd8:  c = mk(M_HL,   S_H1, K_A1, P_LOAD, A_SUB,   J_NONE);
      4'd9:  c = mk(M_HH,   S_H2, K_A2, P_ADD,  A_W,     J_NONE);
      4'd10: c = mk(M_HL,   S_H2, K_A2, P_LOAD, A_ADD,   J_NONE);
      4'd11: c = mk(M_NONE, S_H1, K_B1, P_ADD,  A_NONE,  J_NONE);
      4'd12: c = mk(M_NONE, S_H1, K_B1, P_NONE, A_ADD,   J_NONE);
      4'd13: c = mk(M_NONE, S_H1, K_B1, P_NONE, A_Y,     J_LOOP);
      4'd14: c = mk(M_NONE, S_H1, K_B1, P_NONE, A_NONE,  J_END);
      default: c = mk(M_NONE, S_H1, K_B1, P_NONE, A_NONE, J_END);
    endcase
    return c;
  endfunction

  function automatic logic signed [H_W-1:0] sat_hist(input logic signed [ACC_W-1:0] a);
    if (a > H_MAX_EXT) return H_MAX_EXT[H_W-1:0];
    if (a < H_MIN_EXT) return H_MIN_EXT[H_W-1:0];
    return a[H_W-1:0];
  endfunction

endpackage

// ----- design/biquad_cascade_lowpass_filter_core.sv -----
// Cascaded direct-form-II biquad core with a microcoded shared-multiplier datapath.
// Filtered sample: the sequencer runs the microcode through every section, then the result
// waits for the output register; the next sample is taken in the cycle after it is loaded.
// Pass-through sample: skips the sequencer and goes straight to the finish state.
// The single 25x33 multiplier takes two passes per product and four products per section.
// Synchronous reset clears history and loads the register defaults; no clearing pass.
module biquad_cascade_lowpass_filter_core import bqc_pkg::*; #(
  parameter int SECTIONS = SECTIONS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [X_W-1:0] sample_in,
  input  logic                  from_receive,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [X_W-1:0] sample_out,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data
);

`include "biquad_cascade_lowpass_filter_core_assert.svh"

  localparam int SEC_W = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
  localparam logic signed [Q_W-1:0] Q_XMAX = Q_W'(2 ** (X_W - 1) - 1);
  localparam logic signed [Q_W-1:0] Q_XMIN = -Q_XMAX - 1;

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_FINISH} state_t;

  state_t                state;
  logic [G_W-1:0]        gain;
  logic [CFG_W-1:0]      pole [MAX_SECTIONS];
  logic [CFG_W-1:0]      zero [MAX_SECTIONS];
  logic                  apply_rx;
  logic                  apply_tx;
  logic signed [X_W-1:0] x_hold;
  logic                  pass;
  logic                  accept;
  logic                  enabled;
  logic                  seq_start;
  logic                  out_load;
  ctl_t                  ctl;
  logic [SEC_W-1:0]      sec;
  seq_stat_t             seq_stat;
  logic signed [H_W-1:0] v;
  logic                  round_up;
  logic signed [Q_W-1:0] q;
  logic signed [X_W-1:0] filt;

  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign enabled   = from_receive ? apply_rx : apply_tx;
  assign seq_start = accept && enabled;
  assign out_load  = (state == ST_FINISH) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      gain     <= '0;
      pole[0]  <= '0;
      pole[1]  <= '0;
      zero[0]  <= ZERO_PAIR_RESET;
      zero[1]  <= ZERO_PAIR_RESET;
      apply_rx <= 1'b1;
      apply_tx <= 1'b1;
    end else if (cfg_write) begin
      case (reg_idx_t'(cfg_index))
        R_GAIN:     gain     <= cfg_data[G_W-1:0];
        R_POLE1:    pole[0]  <= cfg_data;
        R_ZERO1:    zero[0]  <= cfg_data;
        R_POLE2:    pole[1]  <= cfg_data;
        R_ZERO2:    zero[1]  <= cfg_data;
        R_APPLY_RX: apply_rx <= cfg_data[0];
        R_APPLY_TX: apply_tx <= cfg_data[0];
        default:    ;
      endcase
    end
  end

  bqc_sequencer #(.SECTIONS(SECTIONS)) u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (seq_start),
    .ctl   (ctl),
    .sec   (sec),
    .stat  (seq_stat)
  );

  bqc_datapath #(.SECTIONS(SECTIONS)) u_dp (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl),
    .sec  (sec),
    .x    (x_hold),
    .gain (gain),
    .pole (pole),
    .zero (zero),
    .v    (v)
  );

  // truncate toward zero: floor, plus one for a negative value with a fraction
  assign round_up = v[H_W-1] && (v[FRAC_W-1:0] != '0);
  assign q = $signed(v[H_W-1:FRAC_W]) + $signed({{(Q_W-1){1'b0}}, round_up});

  always_comb begin
    if (q > Q_XMAX) begin
      filt = Q_XMAX[X_W-1:0];
    end else if (q < Q_XMIN) begin
      filt = Q_XMIN[X_W-1:0];
    end else begin
      filt = q[X_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            x_hold <= sample_in;
            pass   <= !enabled;
            state  <= enabled ? ST_RUN : ST_FINISH;
          end
        end
        ST_RUN: begin
          if (seq_stat.done) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          // hold the result until the output register is free
          if (out_load) begin
            sample_out <= pass ? x_hold : filt;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `BQC_ASSERT_IMPL(a_run_in_state, clk, rst, seq_stat.run, state == ST_RUN, "stray sequencer run")
  `BQC_ASSERT_NEXT(a_start_runs, clk, rst, seq_start, seq_stat.run, "sequencer did not start")
  `BQC_ASSERT_NEXT(a_done_finish, clk, rst, seq_stat.done, state == ST_FINISH, "no finish")

endmodule

// ----- design/bqc_sequencer.sv -----
// microcode sequencer: step counter, section counter and jump logic
// depends on bqc_pkg for the control word and the microcode table
module bqc_sequencer import bqc_pkg::*; #(
  parameter int SECTIONS = SECTIONS_DEF,
  localparam int SEC_W = (SECTIONS > 1) ? $clog2(SECTIONS) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output ctl_t             ctl,
  output logic [SEC_W-1:0] sec,
  output seq_stat_t        stat
);

  logic              run;
  logic [STEP_W-1:0] step;
  ctl_t              word;
  logic              last_sec;

  assign word     = ucode(step);
  assign ctl      = run ? word : CTL_NOP;
  assign last_sec = (sec == SEC_W'(SECTIONS - 1));
  assign stat.run  = run;
  assign stat.done = run && (word.jump == J_END);

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      step <= '0;
      sec  <= '0;
    end else if (start) begin
      run  <= 1'b1;
      step <= '0;
      sec  <= '0;
    end else if (run) begin
      case (word.jump)
        J_END: begin
          run <= 1'b0;
        end
        J_LOOP: begin
          if (!last_sec) begin
            sec  <= sec + 1'b1;
            step <= LOOP_STEP;
          end else begin
            step <= step + 1'b1;
          end
        end
        default: begin
          step <= step + 1'b1;
        end
      endcase
    end
  end

endmodule

// ----- design/bqc_datapath.sv -----
// shared multiplier, product and section accumulators, history registers
// depends on bqc_pkg; driven by the control word from bqc_sequencer
module bqc_datapath import bqc_pkg::*; #(
  parameter int SECTIONS = SECTIONS_DEF,
  localparam int SEC_W = (SECTIONS > 1) ? $clog2(SECTIONS) : 1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  ctl_t                    ctl,
  input  logic [SEC_W-1:0]        sec,
  input  logic signed [X_W-1:0]   x,
  input  logic [G_W-1:0]          gain,
  input  logic [CFG_W-1:0]        pole [MAX_SECTIONS],
  input  logic [CFG_W-1:0]        zero [MAX_SECTIONS],
  output logic signed [H_W-1:0]   v
);

  logic signed [H_W-1:0]   h1 [SECTIONS];
  logic signed [H_W-1:0]   h2 [SECTIONS];
  logic signed [H_W-1:0]   h_sel;
  logic [CFG_W-1:0]        coef_word;
  logic [C_W-1:0]          coef;
  logic signed [MA_W-1:0]  mul_a;
  logic signed [MB_W-1:0]  mul_b;
  logic signed [M_W-1:0]   prod;
  logic signed [M_W-1:0]   mreg;
  logic signed [P_W-1:0]   pacc;
  logic signed [P_W-1:0]   psum;
  logic signed [T_W-1:0]   term;
  logic signed [ACC_W-1:0] acc;
  logic signed [H_W-1:0]   acc_sat;
  logic signed [H_W-1:0]   wreg;

  assign h_sel = (ctl.src == S_H2) ? h2[sec] : h1[sec];

  always_comb begin
    case (ctl.coef)
      K_B1:    begin coef_word = pole[sec]; coef = coef_word[C_W-1:0]; end
      K_B2:    begin coef_word = pole[sec]; coef = coef_word[CFG_W-1:C_W]; end
      K_A1:    begin coef_word = zero[sec]; coef = coef_word[C_W-1:0]; end
      default: begin coef_word = zero[sec]; coef = coef_word[CFG_W-1:C_W]; end
    endcase
  end

  // history split as signed upper part times coefficient plus unsigned lower part
  always_comb begin
    case (ctl.mul)
      M_GAIN: begin
        mul_a = {{(MA_W-X_W){x[X_W-1]}}, x};
        mul_b = {1'b0, gain};
      end
      M_HH: begin
        mul_a = {h_sel[H_W-1], h_sel[H_W-1:HL_W]};
        mul_b = {coef[C_W-1], coef};
      end
      default: begin
        mul_a = {1'b0, h_sel[HL_W-1:0]};
        mul_b = {coef[C_W-1], coef};
      end
    endcase
  end

  assign prod    = mul_a * mul_b;
  assign psum    = pacc + {{(P_W-M_W){mreg[M_W-1]}}, mreg};
  assign acc_sat = sat_hist(acc);

  always_ff @(posedge clk) begin
    if (ctl.mul != M_NONE) begin
      mreg <= prod;
    end
    case (ctl.prod)
      P_LOAD:  pacc <= {{(P_W-M_W){mreg[M_W-1]}}, mreg} <<< HL_W;
      P_ADD:   term <= psum[P_W-1:CSH];
      P_GAIN:  term <= {{(T_W-M_W+FRAC_W){mreg[M_W-1]}}, mreg[M_W-1:FRAC_W]};
      default: ;
    endcase
    case (ctl.acc)
      A_V:     v <= term[H_W-1:0];
      A_LOADV: acc <= {{(ACC_W-H_W){v[H_W-1]}}, v};
      A_SUB:   acc <= acc - {{(ACC_W-T_W){term[T_W-1]}}, term};
      A_ADD:   acc <= acc + {{(ACC_W-T_W){term[T_W-1]}}, term};
      A_W: begin
        wreg <= acc_sat;
        acc  <= {{(ACC_W-H_W){acc_sat[H_W-1]}}, acc_sat};
      end
      A_Y:     v <= acc_sat;
      default: ;
    endcase
  end

  // history shifts once per section, after all four products are taken
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SECTIONS; i++) begin
        h1[i] <= '0;
        h2[i] <= '0;
      end
    end else if (ctl.acc == A_Y) begin
      h2[sec] <= h1[sec];
      h1[sec] <= wreg;
    end
  end

endmodule

// ----- tb/biquad_cascade_lowpass_filter_core_tb.sv -----
// testbench for the cascaded biquad core: directed and random samples checked against
// a fixed-point predictor of the two-section filter, with random stalls on both channels
// depends on bqc_pkg and biquad_cascade_lowpass_filter_core
`timescale 1ns / 100ps

module biquad_cascade_lowpass_filter_core_tb;
  import bqc_pkg::*;

  localparam int QUIET_LIMIT   = 3000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 40;

  localparam logic [CFG_IDX_W-1:0] IDX_UNUSED = 3'd7;

  localparam longint HIST_TOP    = (longint'(1) <<< (H_W - 1)) - 1;
  localparam longint HIST_BOTTOM = -HIST_TOP - 1;
  localparam longint OUT_TOP     = 32767;
  localparam longint OUT_BOTTOM  = -32768;

  // butterworth low-pass at a fifth of nyquist, gain trimmed for unity at dc
  localparam logic [C_W-1:0] LP_B1   = -32'sd306821726;
  localparam logic [C_W-1:0] LP_B2   = 32'sd110810157;
  localparam logic [C_W-1:0] LP_A1   = 32'h2000_0000;
  localparam logic [C_W-1:0] LP_A2   = 32'h1000_0000;
  localparam logic [G_W-1:0] LP_GAIN = 32'd19522579;

  typedef struct packed {
    logic [G_W-1:0]   gain;
    logic [CFG_W-1:0] pole1;
    logic [CFG_W-1:0] zero1;
    logic [CFG_W-1:0] pole2;
    logic [CFG_W-1:0] zero2;
    logic             apply_rx;
    logic             apply_tx;
  } filter_setup_t;

  localparam filter_setup_t LOWPASS = '{
    gain: LP_GAIN, pole1: {LP_B2, LP_B1}, zero1: {LP_A2, LP_A1},
    pole2: {LP_B2, LP_B1}, zero2: {LP_A2, LP_A1}, apply_rx: 1'b1, apply_tx: 1'b1
  };

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic signed [X_W-1:0] sample_in = '0;
  logic                  from_receive = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic signed [X_W-1:0] sample_out;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]      cfg_data = '0;

  // predictor state
  filter_setup_t         live;
  logic signed [H_W-1:0] hist [2*MAX_SECTIONS];

  logic signed [X_W-1:0] expected_samples [$];
  int                    mismatches = 0;
  bit                    tx_steady = 1'b0;
  logic                  pressure_go = 1'b0;
  logic                  pressure_done = 1'b0;

  biquad_cascade_lowpass_filter_core #(
    .SECTIONS(SECTIONS_DEF)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sample_in(sample_in),
    .from_receive(from_receive),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sample_out(sample_out),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint clip_hist(input longint a);
    if (a > HIST_TOP) return HIST_TOP;
    if (a < HIST_BOTTOM) return HIST_BOTTOM;
    return a;
  endfunction

  // floor(h * c / 2^28), exact in 96 bits
  function automatic longint coef_product(input longint h, input logic [C_W-1:0] c);
    logic signed [95:0] hs, cs, p;
    hs = 96'(h);
    cs = 96'($signed(c));
    p = hs * cs;
    return longint'(p >>> CSH);
  endfunction

  function automatic logic signed [X_W-1:0] filter_sample(input logic signed [X_W-1:0] x,
                                                          input logic rx);
    longint           v, w, h1, h2, r;
    logic [CFG_W-1:0] poles, zeros;
    int               s;
    if (!(rx ? live.apply_rx : live.apply_tx)) return x;
    v = (longint'(x) * longint'({32'd0, live.gain})) >>> FRAC_W;
    for (s = 0; s < SECTIONS_DEF; s++) begin
      poles = (s == 0) ? live.pole1 : live.pole2;
      zeros = (s == 0) ? live.zero1 : live.zero2;
      h1 = hist[2*s];
      h2 = hist[2*s+1];
      w = clip_hist(v - coef_product(h1, poles[31:0]) - coef_product(h2, poles[63:32]));
      v = clip_hist(w + coef_product(h1, zeros[31:0]) + coef_product(h2, zeros[63:32]));
      hist[2*s+1] = hist[2*s];
      hist[2*s] = w[H_W-1:0];
    end
    // truncate toward zero, then clamp to the sample range
    r = (v >= 0) ? (v >>> FRAC_W) : -((-v) >>> FRAC_W);
    if (r > OUT_TOP) r = OUT_TOP;
    if (r < OUT_BOTTOM) r = OUT_BOTTOM;
    return r[X_W-1:0];
  endfunction

  function automatic int pick_gap(input bit steady);
    int roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [C_W-1:0] rand_coef();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 32'h7FFF_FFFF;
    if (pick == 1) return 32'h8000_0000;
    if (pick < 5) return $urandom();
    // within +-2.0, where most designs sit
    return $urandom_range(0, 32'h4000_0000) - 32'h2000_0000;
  endfunction

  function automatic logic signed [X_W-1:0] rand_sample();
    int pick;
    pick = $urandom_range(0, 15);
    if (pick == 0) return 16'sh8000;
    if (pick == 1) return 16'sh7FFF;
    if (pick == 2) return X_W'($urandom_range(0, 200) - 100);
    return X_W'($urandom());
  endfunction

  function automatic filter_setup_t rand_setup();
    filter_setup_t s;
    int            pick;
    pick = $urandom_range(0, 7);
    s.gain = (pick == 0) ? '0 : (pick == 1) ? '1 : $urandom();
    s.pole1 = {rand_coef(), rand_coef()};
    s.zero1 = {rand_coef(), rand_coef()};
    s.pole2 = {rand_coef(), rand_coef()};
    s.zero2 = {rand_coef(), rand_coef()};
    s.apply_rx = ($urandom_range(0, 3) != 0);
    s.apply_tx = ($urandom_range(0, 3) != 0);
    return s;
  endfunction

  // leaves cfg_write high; the caller lowers it after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      R_GAIN:     live.gain = data[G_W-1:0];
      R_POLE1:    live.pole1 = data;
      R_ZERO1:    live.zero1 = data;
      R_POLE2:    live.pole2 = data;
      R_ZERO2:    live.zero2 = data;
      R_APPLY_RX: live.apply_rx = data[0];
      R_APPLY_TX: live.apply_tx = data[0];
      default: ;
    endcase
  endtask

  task automatic load_settings(input filter_setup_t s);
    logic [CFG_W-1:0] junk;
    junk = {$urandom(), $urandom()};
    // unused upper bits carry noise that the block must drop
    write_reg(R_GAIN, {junk[63:32], s.gain});
    write_reg(R_POLE1, s.pole1);
    write_reg(R_ZERO1, s.zero1);
    write_reg(R_POLE2, s.pole2);
    write_reg(R_ZERO2, s.zero2);
    write_reg(R_APPLY_RX, {junk[63:1], s.apply_rx});
    write_reg(R_APPLY_TX, {junk[62:0], s.apply_tx});
    cfg_write <= 1'b0;
  endtask

  task automatic send_sample(input logic signed [X_W-1:0] value, input logic rx);
    int gap;
    gap = pick_gap(tx_steady);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample_in <= value;
    from_receive <= rx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_samples.push_back(filter_sample(value, rx));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
  endtask

  task automatic test_reset_gain();
    // gain is zero out of reset, so both directions give silence
    send_sample(16'sh7FFF, 1'b1);
    send_sample(16'sh8000, 1'b0);
  endtask

  task automatic test_pass_through();
    filter_setup_t s;
    drain_results();
    s = live;
    s.apply_rx = 1'b0;
    s.apply_tx = 1'b0;
    load_settings(s);
    send_sample(16'sh8000, 1'b1);
    send_sample(16'sh7FFF, 1'b0);
    send_sample(16'sh0000, 1'b1);
    send_sample(-16'sd1, 1'b0);
    // transmit bypassed while receive filters: history must follow receive only
    drain_results();
    s = LOWPASS;
    s.apply_tx = 1'b0;
    load_settings(s);
    send_sample(16'sd1000, 1'b1);
    send_sample(-16'sd20000, 1'b0);
    send_sample(16'sh7FFF, 1'b1);
    send_sample(16'sd5, 1'b0);
  endtask

  task automatic test_saturation();
    filter_setup_t s;
    int            i;
    drain_results();
    s.gain = '1;
    s.pole1 = {32'h8000_0000, 32'h8000_0000};
    s.zero1 = {32'h7FFF_FFFF, 32'h7FFF_FFFF};
    s.pole2 = s.pole1;
    s.zero2 = s.zero1;
    s.apply_rx = 1'b1;
    s.apply_tx = 1'b1;
    load_settings(s);
    for (i = 0; i < 3; i++) send_sample(16'sh7FFF, 1'b1);
    for (i = 0; i < 3; i++) send_sample(16'sh8000, 1'b0);
    drain_results();
    s.pole1 = {32'h7FFF_FFFF, 32'h7FFF_FFFF};
    s.zero1 = {32'h8000_0000, 32'h8000_0000};
    s.pole2 = s.pole1;
    s.zero2 = s.zero1;
    load_settings(s);
    for (i = 0; i < 4; i++) send_sample(i[0] ? 16'sh8000 : 16'sh7FFF, i[1]);
  endtask

  task automatic test_ignored_index();
    drain_results();
    write_reg(IDX_UNUSED, '1);
    cfg_write <= 1'b0;
    send_sample(16'sd12345, 1'b1);
    send_sample(-16'sd321, 1'b0);
    send_sample(16'sh7FFF, 1'b1);
  endtask

  task automatic test_lowpass_stream();
    int i;
    drain_results();
    load_settings(LOWPASS);
    for (i = 0; i < 200; i++) begin
      tx_steady = (i % 64) < 12;
      send_sample(rand_sample(), 1'($urandom_range(0, 1)));
    end
    tx_steady = 1'b0;
  endtask

  task automatic test_random_settings();
    int phase, i;
    for (phase = 0; phase < 8; phase++) begin
      drain_results();
      load_settings(rand_setup());
      for (i = 0; i < 30; i++) begin
        tx_steady = (phase % 3 == 0) && (i < 10);
        send_sample(rand_sample(), 1'($urandom_range(0, 1)));
      end
    end
    tx_steady = 1'b0;
  endtask

  task automatic test_backpressure();
    int i;
    drain_results();
    load_settings(LOWPASS);
    tx_steady = 1'b1;
    pressure_go <= 1'b1;
    for (i = 0; i < 30; i++) send_sample(rand_sample(), 1'($urandom_range(0, 1)));
    tx_steady = 1'b0;
  endtask

  initial begin
    live.gain = '0;
    live.pole1 = '0;
    live.zero1 = ZERO_PAIR_RESET;
    live.pole2 = '0;
    live.zero2 = ZERO_PAIR_RESET;
    live.apply_rx = 1'b1;
    live.apply_tx = 1'b1;
    foreach (hist[k]) hist[k] = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_reset_gain();
    test_pass_through();
    test_saturation();
    test_ignored_index();
    test_lowpass_stream();
    test_random_settings();
    test_backpressure();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_samples.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  // receiver: random stalls, steady stretches, and one long hold-off on request
  initial begin : receiver
    int stall_left, held, span;
    bit rx_steady;
    stall_left = 0;
    held = 0;
    span = 0;
    rx_steady = 1'b0;
    forever begin
      @(posedge clk);
      span++;
      if (span == 256) begin
        span = 0;
        rx_steady = ($urandom_range(0, 3) == 0);
      end
      if (pressure_go && !pressure_done) begin
        out_ready <= 1'b0;
        held++;
        if (held == HOLD_CYCLES) pressure_done <= 1'b1;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        stall_left = pick_gap(rx_steady);
      end
    end
  end

  always @(posedge clk) begin : result_check
    logic signed [X_W-1:0] want;
    if (!rst && out_valid && out_ready) begin
      if (expected_samples.size() == 0) begin
        $error("sample_out: no transaction expected, got %0d", sample_out);
        mismatches++;
      end else begin
        want = expected_samples.pop_front();
        if (sample_out !== want) begin
          $error("sample_out: expected %0d, got %0d", want, sample_out);
          mismatches++;
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready))
        quiet = 0;
      else
        quiet++;
    end
    $error("no transaction for %0d cycles", QUIET_LIMIT);
    $display("tb: failure");
    $finish;
  end

endmodule
